FILE: rtl/core/cprle_pkg.sv
// shared types and constants for the column pack run-length encoder
// no dependencies; imported by the controller, datapath and top level
package cprle_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam logic [BYTE_W-1:0] RUN_MAX = 8'd255;
	localparam logic [BYTE_W-1:0] ZERO_LEVEL = 8'h00;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PRIME = 6'b000010,
		ST_FEED  = 6'b000100,
		ST_FLUSH = 6'b001000,
		ST_TERM  = 6'b010000,
		ST_DONE  = 6'b100000
	} cprle_state_t;

	typedef struct packed {
		logic accept;
		logic feed_step;
		logic flush;
		logic term;
		logic finish;
	} cprle_cmd_t;

	typedef struct packed {
		logic col_end;
		logic feed_last;
		logic hold_valid;
		logic out_free;
		logic run_open;
	} cprle_status_t;

endpackage

FILE: rtl/core/cprle_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cprle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/cprle_dp.sv
// datapath: bit packing, column store, run-length state, hold and output registers
// depends on cprle_pkg and cprle_ram
module cprle_dp
	import cprle_pkg::*;
#(
	parameter int unsigned COLUMN_HEIGHT = 128,
	parameter int unsigned COLUMN_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cprle_cmd_t    cmd,
	output cprle_status_t status,
	input  logic [7:0]    pixel_level,
	input  logic          end_of_image,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    run_count,
	output logic [7:0]    run_value,
	output logic          is_terminator,
	output logic          last_of_burst
);

	localparam int unsigned RW = $clog2(COLUMN_HEIGHT);
	localparam int unsigned AW = (COLUMN_BYTES > 1) ? $clog2(COLUMN_BYTES) : 1;

	logic [7:0]    acc_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] byte_q;
	logic          pass_q;
	logic [7:0]    cur_val_q;
	logic [7:0]    cur_cnt_q;
	logic          open_q;
	logic          hold_valid_q;
	logic [7:0]    hold_cnt_q;
	logic [7:0]    hold_val_q;
	logic          hold_term_q;
	logic          out_valid_q;
	logic [7:0]    out_cnt_q;
	logic [7:0]    out_val_q;
	logic          out_term_q;
	logic          out_last_q;

	logic [7:0]    acc_next;
	logic [RW-1:0] idx_full;
	logic          byte_done;
	logic          col_end;
	logic          ram_we;
	logic [AW-1:0] byte_next;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          byte_wrap;
	logic          feed_emit;
	logic          emit;
	logic [7:0]    emit_cnt;
	logic [7:0]    emit_val;
	logic          emit_term;
	logic          out_free;

	assign acc_next  = {acc_q[6:0], (pixel_level == ZERO_LEVEL)};
	assign idx_full  = row_q >> 3;
	assign byte_done = (row_q[2:0] == 3'd7);
	assign col_end   = (row_q == RW'(COLUMN_HEIGHT - 1));
	assign ram_we    = cmd.accept && byte_done && (32'(idx_full) < COLUMN_BYTES);

	assign byte_wrap = (byte_q == AW'(COLUMN_BYTES - 1));
	assign byte_next = byte_wrap ? '0 : byte_q + AW'(1);
	assign rd_addr   = cmd.feed_step ? byte_next : byte_q;

	cprle_ram #(
		.WIDTH(8),
		.DEPTH(COLUMN_BYTES)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(AW'(idx_full)),
		.wr_data(acc_next),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign feed_emit = open_q && ((rd_data != cur_val_q) || (cur_cnt_q == RUN_MAX));
	assign emit      = (cmd.feed_step && feed_emit) || cmd.flush || cmd.term;
	assign emit_cnt  = cmd.term ? 8'd0 : cur_cnt_q;
	assign emit_val  = cmd.term ? 8'd0 : cur_val_q;
	assign emit_term = cmd.term;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			row_q  <= '0;
			byte_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (col_end || end_of_image) begin
					row_q <= '0;
					acc_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
					acc_q <= byte_done ? 8'd0 : acc_next;
				end
				byte_q <= '0;
				pass_q <= 1'b0;
			end else if (cmd.feed_step) begin
				byte_q <= byte_next;
				if (byte_wrap) begin
					pass_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_val_q <= '0;
			cur_cnt_q <= '0;
			open_q    <= 1'b0;
		end else begin
			if (cmd.feed_step) begin
				if (!open_q || feed_emit) begin
					open_q    <= 1'b1;
					cur_val_q <= rd_data;
					cur_cnt_q <= 8'd1;
				end else begin
					cur_cnt_q <= cur_cnt_q + 8'd1;
				end
			end else if (cmd.flush || cmd.term) begin
				open_q    <= 1'b0;
				cur_val_q <= '0;
				cur_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end
			if ((emit || cmd.finish) && hold_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hold_cnt_q  <= emit_cnt;
			hold_val_q  <= emit_val;
			hold_term_q <= emit_term;
		end
		if ((emit || cmd.finish) && hold_valid_q) begin
			out_cnt_q  <= hold_cnt_q;
			out_val_q  <= hold_val_q;
			out_term_q <= hold_term_q;
			out_last_q <= cmd.finish;
		end
	end

	assign status.col_end    = col_end;
	assign status.feed_last  = pass_q && byte_wrap;
	assign status.hold_valid = hold_valid_q;
	assign status.out_free   = out_free;
	assign status.run_open   = open_q;

	assign out_valid     = out_valid_q;
	assign run_count     = out_cnt_q;
	assign run_value     = out_val_q;
	assign is_terminator = out_term_q;
	assign last_of_burst = out_last_q;

endmodule

FILE: rtl/core/cprle_ctrl.sv
// controller state machine sequencing pixel intake, column feed, flush and terminator
// depends on cprle_pkg
module cprle_ctrl
	import cprle_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          end_of_image,
	output logic          in_ready,
	input  cprle_status_t status,
	output cprle_cmd_t    cmd
);

	cprle_state_t state_q;
	cprle_state_t state_next;
	logic         eoi_q;
	logic         can_emit;

	assign can_emit = status.out_free || !status.hold_valid;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.col_end) begin
						state_next = ST_PRIME;
					end else if (end_of_image) begin
						state_next = ST_FLUSH;
					end
				end
			end
			ST_PRIME: begin
				state_next = ST_FEED;
			end
			ST_FEED: begin
				if (can_emit) begin
					cmd.feed_step = 1'b1;
					if (status.feed_last) begin
						state_next = eoi_q ? ST_FLUSH : ST_DONE;
					end
				end
			end
			ST_FLUSH: begin
				if (!status.run_open) begin
					state_next = ST_TERM;
				end else if (can_emit) begin
					cmd.flush  = 1'b1;
					state_next = ST_TERM;
				end
			end
			ST_TERM: begin
				if (can_emit) begin
					cmd.term   = 1'b1;
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.hold_valid) begin
					state_next = ST_IDLE;
				end else if (status.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eoi_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.accept) begin
				eoi_q <= end_of_image;
			end
		end
	end

endmodule

FILE: rtl/core/column_pack_run_length_encoder_unit.sv
// channel  dir  tdata                          tuser             tlast
// s_axis   in   [7:0] pixel_level              -                 end_of_image
// m_axis   out  [7:0] run_count [15:8] value   [0] is_terminator last_of_burst
//
// a pixel that ends neither a column nor the image leaves the controller idle for the next
// a column-ending pixel stalls intake while the store is read and fed twice to the encoder
// end of image adds the flush, terminator and burst close steps
// output backpressure stalls the feed only when the hold and output registers are both full
// reset is asynchronous and clears all control and run state at once
//
// top level of the column pack run-length encoder
// depends on cprle_pkg, cprle_ctrl, cprle_dp
module column_pack_run_length_encoder_unit
	import cprle_pkg::*;
#(
	parameter int unsigned COLUMN_HEIGHT = 128,
	parameter int unsigned COLUMN_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_level
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] run_count, [15:8] run_value
	output logic [0:0]  m_axis_tuser,   // [0] is_terminator
	output logic        m_axis_tlast
);

	cprle_cmd_t    cmd;
	cprle_status_t status;
	logic [7:0]    run_count;
	logic [7:0]    run_value;
	logic          is_terminator;

	cprle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.end_of_image(s_axis_tlast),
		.in_ready    (s_axis_tready),
		.status      (status),
		.cmd         (cmd)
	);

	cprle_dp #(
		.COLUMN_HEIGHT(COLUMN_HEIGHT),
		.COLUMN_BYTES (COLUMN_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.pixel_level  (s_axis_tdata),
		.end_of_image (s_axis_tlast),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.run_count    (run_count),
		.run_value    (run_value),
		.is_terminator(is_terminator),
		.last_of_burst(m_axis_tlast)
	);

	assign m_axis_tdata = {run_value, run_count};
	assign m_axis_tuser = is_terminator;

endmodule

FILE: rtl/core/cprle_chk.sv
// port-level checker for the column pack run-length encoder, with its bind
// depends on column_pack_run_length_encoder_unit
module cprle_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
		else $error("terminator item is not a zero pair");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] != 8'd0)
		else $error("run item with zero count");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("terminator item not closing its burst");

endmodule

bind column_pack_run_length_encoder_unit cprle_chk u_cprle_chk (.*);

FILE: sim/column_pack_run_length_encoder_unit_tb.sv
// self-checking testbench for column_pack_run_length_encoder_unit: streams pixel columns and images
// into s_axis and checks each run pair on m_axis against a scoreboard that packs and encodes in step
// depends on cprle_pkg and the rtl of the unit
module column_pack_run_length_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cprle_pkg::*;

	localparam int unsigned COL_HEIGHT = 128;
	localparam int unsigned COL_BYTES = 16;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic [7:0] run_len;
		logic [7:0] run_byte;
		logic       is_term;
		logic       burst_end;
	} run_pair_t;

	typedef logic [7:0] column_t [COL_BYTES];

	class rle_scoreboard;
		logic [7:0] pack_bits;
		int unsigned row_pos;
		logic [7:0] col_bytes [COL_BYTES];
		logic [7:0] open_byte;
		logic [7:0] open_len;
		bit open_live;
		run_pair_t pending_pairs [$];
		int unsigned failures;
		int unsigned pairs_made;
		int unsigned pairs_checked;
		int unsigned columns_fed;
		int unsigned images_closed;
		int unsigned run_splits;

		function new();
			clear_image();
			foreach (col_bytes[i])
				col_bytes[i] = '0;
		endfunction

		function void clear_image();
			pack_bits = '0;
			row_pos = 0;
			open_byte = '0;
			open_len = '0;
			open_live = 1'b0;
		endfunction

		function void push_pair(logic [7:0] len, logic [7:0] byte_val, logic term);
			run_pair_t p;
			p.run_len = len;
			p.run_byte = byte_val;
			p.is_term = term;
			p.burst_end = 1'b0;
			pending_pairs.push_back(p);
			pairs_made++;
		endfunction

		function int unsigned pending();
			return pending_pairs.size();
		endfunction

		function void note_pixel(logic [7:0] level, logic eoi);
			int unsigned n_prior;
			logic [7:0] b;
			run_pair_t tail;
			n_prior = pending_pairs.size();
			pack_bits = {pack_bits[6:0], level == ZERO_LEVEL};
			if (row_pos % 8 == 7) begin
				if (row_pos / 8 < COL_BYTES)
					col_bytes[row_pos / 8] = pack_bits;
				pack_bits = '0;
			end
			if (row_pos >= COL_HEIGHT - 1) begin
				// column store goes through the encoder twice
				for (int k = 0; k < 2 * COL_BYTES; k++) begin
					b = col_bytes[k % COL_BYTES];
					if (!open_live) begin
						open_live = 1'b1;
						open_byte = b;
						open_len = 8'd1;
					end else if (b == open_byte && open_len != RUN_MAX) begin
						open_len++;
					end else begin
						if (b == open_byte)
							run_splits++;
						push_pair(open_len, open_byte, 1'b0);
						open_byte = b;
						open_len = 8'd1;
					end
				end
				row_pos = 0;
				pack_bits = '0;
				columns_fed++;
			end else begin
				row_pos++;
			end
			if (eoi) begin
				if (open_live)
					push_pair(open_len, open_byte, 1'b0);
				push_pair(8'd0, 8'd0, 1'b1);
				clear_image();
				images_closed++;
			end
			if (pending_pairs.size() > n_prior) begin
				tail = pending_pairs.pop_back();
				tail.burst_end = 1'b1;
				pending_pairs.push_back(tail);
			end
		endfunction

		function void check_result(run_pair_t seen);
			run_pair_t want;
			if (pending_pairs.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("%0t: unexpected pair len %0d byte %02h term %b end %b",
						$time, seen.run_len, seen.run_byte, seen.is_term, seen.burst_end);
				return;
			end
			want = pending_pairs.pop_front();
			pairs_checked++;
			if (seen !== want) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("%0t: expected len %0d byte %02h term %b end %b, got len %0d byte %02h term %b end %b",
						$time, want.run_len, want.run_byte, want.is_term, want.burst_end,
						seen.run_len, seen.run_byte, seen.is_term, seen.burst_end);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] pixel_level
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [7:0] run_count, [15:8] run_value
	logic [0:0]  m_axis_tuser;        // [0] is_terminator
	logic        m_axis_tlast;

	rle_scoreboard sb = new();
	int unsigned gap_one_in = 0;
	int unsigned stall_one_in = 0;
	bit long_hold_req = 1'b0;
	int unsigned pixels_sent = 0;

	column_pack_run_length_encoder_unit #(
		.COLUMN_HEIGHT(COL_HEIGHT),
		.COLUMN_BYTES(COL_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : receiver
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (stall_one_in != 0 && $urandom_range(1, stall_one_in) == 1) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		run_pair_t seen;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser[0], m_axis_tlast};
			sb.check_result(seen);
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_pixel(input logic [7:0] level, input logic eoi);
		if (gap_one_in != 0 && $urandom_range(1, gap_one_in) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= level;
		s_axis_tlast <= eoi;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_pixel(level, eoi);
		pixels_sent++;
		@(negedge clk);
	endtask

	// first pixel of each byte is its msb; dark bits become level zero
	task automatic send_column(input column_t col, input logic eoi_on_last);
		logic [7:0] level;
		for (int i = 0; i < COL_BYTES; i++) begin
			for (int b = 7; b >= 0; b--) begin
				level = col[i][b] ? ZERO_LEVEL : 8'($urandom_range(1, 255));
				send_pixel(level, eoi_on_last && i == COL_BYTES - 1 && b == 0);
			end
		end
	endtask

	task automatic send_partial(input int unsigned n);
		logic [7:0] level;
		for (int unsigned k = 0; k < n; k++) begin
			level = $urandom_range(0, 1) ? ZERO_LEVEL : 8'($urandom_range(1, 255));
			send_pixel(level, k == n - 1);
		end
	endtask

	initial begin : stimulus
		column_t col;
		int unsigned images;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// lone terminator with no open run
		stall_one_in = 6;
		send_pixel(8'd255, 1'b1);
		// receiver holds off while an alternating column is fed: long burst
		gap_one_in = 0;
		long_hold_req = 1'b1;
		foreach (col[i])
			col[i] = i[0] ? 8'h5A : 8'hA5;
		send_column(col, 1'b0);
		// image ends mid column with the run still open
		send_partial(8);

		images = 0;
		while (pixels_sent < 160 || images < 4) begin
			case ($urandom_range(0, 2))
				0: gap_one_in = 0;
				1: gap_one_in = 4;
				default: gap_one_in = 16;
			endcase
			case ($urandom_range(0, 2))
				0: stall_one_in = 0;
				1: stall_one_in = 3;
				default: stall_one_in = 12;
			endcase
			send_partial($urandom_range(1, 6));
			images++;
		end

		// closing image at full rate on both sides
		gap_one_in = 0;
		stall_one_in = 0;
		send_partial(6);
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d pixels in %0d images, %0d columns fed twice through the encoder",
			pixels_sent, sb.images_closed, sb.columns_fed);
		$display("%0d run pairs checked, %0d runs split at full length, one long output hold",
			sb.pairs_checked, sb.run_splits);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
